@@ rtl/sqt_pkg.sv @@
// Package for the swap space quota table: table size, field widths,
// status and command codes, sequencer states. No dependencies.
`timescale 1ns / 1ps

package sqt_pkg;

	// table size and derived widths
	localparam int ENTRIES = 16;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W   = $clog2(ENTRIES + 1);

	// field widths
	localparam int DATA_W   = 16;
	localparam int STATUS_W = 2;

	// configuration port
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic [APB_AW-3:0] REG_CAPACITY = 1'b0;
	localparam logic [DATA_W-1:0] CAPACITY_RESET = 16'd512;

	// command codes
	localparam logic KIND_RESERVE = 1'b0;
	localparam logic KIND_RELEASE = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] STAT_DONE      = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_NO_SPACE  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd3;

	// one table entry as held in the entry RAM
	typedef struct packed {
		logic [DATA_W-1:0] pid;
		logic [DATA_W-1:0] amount;
	} entry_t;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_CALC,
		S_DECIDE,
		S_FINISH
	} seq_state_t;

endpackage

@@ rtl/sqt_if.sv @@
// Valid/ready channel interfaces for request and response transfers.
// Depends on sqt_pkg for field widths.
`timescale 1ns / 1ps

// request channel: one reserve or release command
interface sqt_req_if;
	logic                        valid;
	logic                        ready;
	logic                        kind;
	logic [sqt_pkg::DATA_W-1:0]  pid;
	logic [sqt_pkg::DATA_W-1:0]  amount;

	modport source (output valid, kind, pid, amount, input ready);
	modport sink   (input valid, kind, pid, amount, output ready);
endinterface

// response channel: status and totals after one command
interface sqt_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [sqt_pkg::STATUS_W-1:0] status;
	logic [sqt_pkg::DATA_W-1:0]   released;
	logic [sqt_pkg::DATA_W-1:0]   used_total;
	logic [sqt_pkg::DATA_W-1:0]   free_total;

	modport source (output valid, status, released, used_total, free_total, input ready);
	modport sink   (input valid, status, released, used_total, free_total, output ready);
endinterface

@@ rtl/sqt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sqt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/swap_space_quota_table.sv @@
// Top level of the swap space quota table: sequencer, scan compare unit,
// totals arithmetic and APB capacity register. Depends on sqt_pkg, sqt_if
// and sqt_ram.
`timescale 1ns / 1ps

// Each command is taken in one transfer and answered by exactly one response
// transfer. After acceptance the entry RAM is read one entry per cycle
// through a single registered read port and each entry passes the one pid
// compare unit, followed by steps that form the base total, decide and
// commit, and load the response register, which waits while an earlier
// response is still held. The response register lets the next command be
// accepted while the previous response still waits. Capacity is written over
// APB at byte address 0 and should only be changed while no command is in
// flight; lowering it below the used total keeps all entries and reports a
// free total of zero.
module swap_space_quota_table (
	input  logic                        clk,
	input  logic                        arst_n,
	sqt_req_if.sink                     req,
	sqt_rsp_if.source                   rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sqt_pkg::APB_AW-1:0]  paddr,
	input  logic [sqt_pkg::APB_DW-1:0]  pwdata,
	output logic [sqt_pkg::APB_DW-1:0]  prdata,
	output logic                        pready
);

	import sqt_pkg::*;

	seq_state_t state_q, state_d;

	// control registers
	logic [CNT_W-1:0]  cnt_q;
	logic              chk_q;
	logic              hit_q;
	logic              free_found_q;
	logic              entry_valid_q [ENTRIES];
	logic [DATA_W-1:0] used_q;
	logic [DATA_W-1:0] cap_q;
	logic              out_valid_q;

	// payload registers
	logic                kind_q;
	logic [DATA_W-1:0]   pid_q;
	logic [DATA_W-1:0]   amount_q;
	logic [IDX_W-1:0]    chk_idx_q;
	logic [IDX_W-1:0]    hit_idx_q;
	logic [IDX_W-1:0]    free_idx_q;
	logic [DATA_W-1:0]   old_q;
	logic [DATA_W-1:0]   base_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [DATA_W-1:0]   res_rel_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [DATA_W-1:0]   out_rel_q;
	logic [DATA_W-1:0]   out_used_q;
	logic [DATA_W-1:0]   out_free_q;

	// entry RAM
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	entry_t           ram_wdata;
	logic [IDX_W-1:0] ram_raddr;
	entry_t           ram_rdata;

	// sequencer controls
	logic req_take;
	logic scan_issue;
	logic scan_last;
	logic out_load;
	logic cfg_write;

	// scan compare unit
	logic chk_valid;
	logic chk_match;
	logic chk_free;

	// decide arithmetic
	logic [DATA_W:0]     total;
	logic                over;
	logic                dec_commit;
	logic [STATUS_W-1:0] dec_status;
	logic [IDX_W-1:0]    dec_slot;
	logic [DATA_W-1:0]   dec_used;
	logic [DATA_W-1:0]   free_calc;

	sqt_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (ENTRIES)
	) u_entry_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// APB: capacity register, no wait states
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && (paddr[APB_AW-1:2] == REG_CAPACITY);
	assign prdata    = (paddr[APB_AW-1:2] == REG_CAPACITY)
		? {{(APB_DW-DATA_W){1'b0}}, cap_q} : '0;

	// next-state logic
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (req.valid) state_d = S_SCAN;
			S_SCAN:   if (scan_last) state_d = S_CALC;
			S_CALC:   state_d = S_DECIDE;
			S_DECIDE: state_d = S_FINISH;
			S_FINISH: if (!out_valid_q || rsp.ready) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		req.ready  = (state_q == S_IDLE);
		scan_last  = (state_q == S_SCAN) && (cnt_q == CNT_W'(ENTRIES));
		scan_issue = (state_q == S_SCAN) && !scan_last;
		out_load   = (state_q == S_FINISH) && (!out_valid_q || rsp.ready);
		ram_raddr  = cnt_q[IDX_W-1:0];
		ram_we     = (state_q == S_DECIDE) && dec_commit && (kind_q == KIND_RESERVE);
	end
	assign req_take = req.valid && req.ready;

	// compare the entry read in the previous cycle
	assign chk_valid = entry_valid_q[chk_idx_q];
	assign chk_match = chk_q && chk_valid && (ram_rdata.pid == pid_q);
	assign chk_free  = chk_q && !chk_valid;

	// reserve total check and the outcome of reserve and release
	assign total = {1'b0, base_q} + ((kind_q == KIND_RESERVE) ? {1'b0, amount_q} : '0);
	assign over  = total > {1'b0, cap_q};

	always_comb begin
		dec_commit = 1'b0;
		dec_status = STAT_DONE;
		dec_slot   = hit_q ? hit_idx_q : free_idx_q;
		dec_used   = used_q;
		if (kind_q == KIND_RESERVE) begin
			if (over) begin
				dec_status = STAT_NO_SPACE;
			end else if (!hit_q && !free_found_q) begin
				dec_status = STAT_FULL;
			end else begin
				dec_commit = 1'b1;
				dec_used   = total[DATA_W-1:0];
			end
		end else begin
			if (!hit_q) begin
				dec_status = STAT_NOT_FOUND;
			end else begin
				dec_commit = 1'b1;
				dec_used   = base_q;
			end
		end
	end

	assign ram_waddr = dec_slot;
	assign ram_wdata = '{pid: pid_q, amount: amount_q};

	// free total, saturating at zero
	assign free_calc = (cap_q > used_q) ? (cap_q - used_q) : '0;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			chk_q        <= 1'b0;
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
			used_q       <= '0;
			cap_q        <= CAPACITY_RESET;
			out_valid_q  <= 1'b0;
			for (int i = 0; i < ENTRIES; i++) begin
				entry_valid_q[i] <= 1'b0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_write) begin
				cap_q <= pwdata[DATA_W-1:0];
			end
			if (req_take) begin
				cnt_q        <= '0;
				chk_q        <= 1'b0;
				hit_q        <= 1'b0;
				free_found_q <= 1'b0;
			end
			if (state_q == S_SCAN) begin
				chk_q <= scan_issue;
				if (scan_issue) begin
					cnt_q <= cnt_q + 1'b1;
				end
				if (chk_match && !hit_q) begin
					hit_q <= 1'b1;
				end
				if (chk_free && !free_found_q) begin
					free_found_q <= 1'b1;
				end
			end
			if (state_q == S_DECIDE && dec_commit) begin
				used_q <= dec_used;
				entry_valid_q[dec_slot] <= (kind_q == KIND_RESERVE);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req_take) begin
			kind_q   <= req.kind;
			pid_q    <= req.pid;
			amount_q <= req.amount;
			old_q    <= '0;
		end
		if (state_q == S_SCAN) begin
			chk_idx_q <= cnt_q[IDX_W-1:0];
			if (chk_match && !hit_q) begin
				hit_idx_q <= chk_idx_q;
				old_q     <= ram_rdata.amount;
			end
			if (chk_free && !free_found_q) begin
				free_idx_q <= chk_idx_q;
			end
		end
		// base total: used minus the amount of the matching entry
		if (state_q == S_CALC) begin
			base_q <= (used_q >= old_q) ? (used_q - old_q) : '0;
		end
		if (state_q == S_DECIDE) begin
			res_status_q <= dec_status;
			res_rel_q    <= dec_commit ? old_q : '0;
		end
		if (out_load) begin
			out_status_q <= res_status_q;
			out_rel_q    <= res_rel_q;
			out_used_q   <= used_q;
			out_free_q   <= free_calc;
		end
	end

	// response channel
	assign rsp.valid      = out_valid_q;
	assign rsp.status     = out_status_q;
	assign rsp.released   = out_rel_q;
	assign rsp.used_total = out_used_q;
	assign rsp.free_total = out_free_q;

	// a found entry stays valid until the decision
	a_hit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN || state_q == S_CALC) && hit_q |-> entry_valid_q[hit_idx_q])
		else $error("matched entry is not valid");

	// an accepted command always starts a scan
	a_take_scan: assert property (@(posedge clk) disable iff (!arst_n)
		req_take |=> (state_q == S_SCAN) && (cnt_q == '0))
		else $error("accepted command did not start a scan");

	// finishing a command always presents a response
	a_finish_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid_q && (state_q == S_IDLE))
		else $error("response not presented after finish");

	// a refused command leaves the used total alone
	a_refused_keep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DECIDE) && !dec_commit |=> $stable(used_q))
		else $error("used total changed on a refused command");

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for swap_space_quota_table: reserve/release requests
// with random pacing, an in-bench quota table predictor and APB capacity writes.
// Depends on rtl/sqt_pkg.sv, rtl/sqt_if.sv and the swap_space_quota_table RTL.
`timescale 1ns / 1ps

module testbench;
	import sqt_pkg::*;

	localparam int     ITEMS_PER_PHASE = 150;
	localparam int     SETTLE_CYCLES   = 2 * (ENTRIES + 5);
	localparam int     CYCLE_LIMIT     = 400000;
	localparam int     POOL_SIZE       = 24;
	localparam logic [APB_AW-1:0] CAPACITY_ADDR = {REG_CAPACITY, 2'b00};

	typedef struct packed {
		logic              kind;
		logic [DATA_W-1:0] pid;
		logic [DATA_W-1:0] amount;
	} request_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [DATA_W-1:0]   released;
		logic [DATA_W-1:0]   used_total;
		logic [DATA_W-1:0]   free_total;
	} response_t;

	typedef enum logic [1:0] {
		RX_ALWAYS,
		RX_COIN,
		RX_ONE_IN_FOUR,
		RX_LONG_STALLS
	} rx_mode_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	sqt_req_if req ();
	sqt_rsp_if rsp ();

	swap_space_quota_table DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// shadow of the quota table
	logic [DATA_W-1:0] quota_capacity;
	bit                quota_valid [ENTRIES];
	logic [DATA_W-1:0] quota_pid [ENTRIES];
	logic [DATA_W-1:0] quota_amount [ENTRIES];
	logic [DATA_W-1:0] quota_used;

	request_t  pending_requests [$];
	response_t expected_responses [$];
	logic [DATA_W-1:0] id_pool [POOL_SIZE];

	request_t  accepted_request;
	response_t oldest_expected;
	int        fail_count = 0;
	int        requests_accepted = 0;
	int        responses_checked = 0;
	int        capacity_settings = 1;
	int        status_count [4] = '{0, 0, 0, 0};
	int        cycle_count = 0;

	logic      req_taken = 1'b0;
	int        burst_left = 1;
	int        gap_left = 0;
	rx_mode_t  rx_mode = RX_ALWAYS;
	int        rx_stretch_left = 0;
	int        rx_stall_left = 0;
	logic [1:0] rx_phase = '0;

	// Apply one request to the shadow table and return the response it must produce.
	function automatic response_t apply_quota_request(request_t r);
		response_t         res;
		int                hit;
		int                slot;
		logic [DATA_W-1:0] old_amount;
		logic [DATA_W-1:0] base;
		logic [DATA_W:0]   total;
		hit  = -1;
		slot = -1;
		// walk downward so both searches end on the lowest index
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (quota_valid[i] && quota_pid[i] == r.pid)
				hit = i;
			if (!quota_valid[i])
				slot = i;
		end
		res        = '0;
		res.status = STAT_DONE;
		if (r.kind == KIND_RESERVE) begin
			// a stored id gives back its old amount before the new one is checked
			old_amount = (hit >= 0) ? quota_amount[hit] : '0;
			base       = (quota_used >= old_amount) ? quota_used - old_amount : '0;
			total      = {1'b0, base} + r.amount;
			if (hit >= 0)
				slot = hit;
			if (total > {1'b0, quota_capacity}) begin
				res.status = STAT_NO_SPACE;
			end else if (slot < 0) begin
				res.status = STAT_FULL;
			end else begin
				quota_valid[slot]  = 1'b1;
				quota_pid[slot]    = r.pid;
				quota_amount[slot] = r.amount;
				quota_used         = total[DATA_W-1:0];
				res.released       = old_amount;
			end
		end else if (hit < 0) begin
			res.status = STAT_NOT_FOUND;
		end else begin
			res.released     = quota_amount[hit];
			quota_used       = (quota_used >= res.released) ? quota_used - res.released : '0;
			quota_valid[hit] = 1'b0;
		end
		res.used_total = quota_used;
		res.free_total = (quota_capacity > quota_used) ? quota_capacity - quota_used : '0;
		return res;
	endfunction

	// Mostly ids from a small pool so reserves and releases meet stored entries;
	// amounts mostly small against the current capacity.
	function automatic request_t random_request();
		request_t r;
		int       sel;
		r.kind = ($urandom_range(0, 99) < 35) ? KIND_RELEASE : KIND_RESERVE;
		sel = $urandom_range(0, 19);
		if (sel < 17)
			r.pid = id_pool[$urandom_range(0, POOL_SIZE - 1)];
		else if (sel < 19)
			r.pid = DATA_W'($urandom);
		else
			r.pid = $urandom_range(0, 1) ? '1 : '0;
		sel = $urandom_range(0, 19);
		if (sel < 12)
			r.amount = DATA_W'($urandom_range(0, quota_capacity / 32 + 1));
		else if (sel < 17)
			r.amount = DATA_W'($urandom_range(0, quota_capacity));
		else
			r.amount = DATA_W'($urandom);
		return r;
	endfunction

	task automatic queue_request(input logic kind, input logic [DATA_W-1:0] pid,
			input logic [DATA_W-1:0] amount);
		request_t r;
		r.kind   = kind;
		r.pid    = pid;
		r.amount = amount;
		pending_requests.push_back(r);
	endtask

	// hold until every request is taken and answered, then let the block settle
	task automatic wait_until_idle();
		while (pending_requests.size() != 0 || expected_responses.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// APB write of the capacity register followed by a read back
	task automatic write_capacity(input logic [DATA_W-1:0] value);
		logic [APB_DW-1:0] readback;
		@(negedge clk);
		psel    = 1'b1;
		pwrite  = 1'b1;
		penable = 1'b0;
		paddr   = CAPACITY_ADDR;
		pwdata  = APB_DW'(value);
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		quota_capacity = value;
		capacity_settings++;
		@(negedge clk);
		psel = 1'b1;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		readback = prdata;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		if (readback[DATA_W-1:0] !== value) begin
			$error("capacity: expected %0d, actual %0d", value, readback[DATA_W-1:0]);
			fail_count++;
		end
	endtask

	task automatic compare_field(input string name, input logic [DATA_W-1:0] want,
			input logic [DATA_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endtask

	// request driver: bursts of transfers separated by random gaps
	always @(negedge clk) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
		end else if (!req.valid || req_taken) begin
			if (gap_left > 0) begin
				req.valid <= 1'b0;
				gap_left  <= gap_left - 1;
			end else if (pending_requests.size() > 0) begin
				req.valid  <= 1'b1;
				req.kind   <= pending_requests[0].kind;
				req.pid    <= pending_requests[0].pid;
				req.amount <= pending_requests[0].amount;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 12);
					gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	// request transfer: predict its response
	always @(posedge clk) begin
		req_taken <= arst_n && req.valid && req.ready;
		if (arst_n && req.valid && req.ready) begin
			accepted_request = {req.kind, req.pid, req.amount};
			expected_responses.push_back(apply_quota_request(accepted_request));
			void'(pending_requests.pop_front());
			requests_accepted++;
		end
	end

	// response ready: a randomly chosen stall pattern, changed after a random stretch
	always @(negedge clk) begin
		if (rx_stretch_left == 0) begin
			rx_mode         <= rx_mode_t'($urandom_range(0, 3));
			rx_stretch_left <= $urandom_range(40, 200);
		end else begin
			rx_stretch_left <= rx_stretch_left - 1;
		end
		case (rx_mode)
			RX_ALWAYS: begin
				rsp.ready <= 1'b1;
			end
			RX_COIN: begin
				rsp.ready <= 1'($urandom_range(0, 1));
			end
			RX_ONE_IN_FOUR: begin
				rsp.ready <= (rx_phase == 2'd0);
				rx_phase  <= rx_phase + 2'd1;
			end
			default: begin
				if (rx_stall_left > 0) begin
					rsp.ready     <= 1'b0;
					rx_stall_left <= rx_stall_left - 1;
				end else begin
					rsp.ready     <= 1'b1;
					rx_stall_left <= $urandom_range(0, 24);
				end
			end
		endcase
	end

	// response monitor: compare against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_responses.size() == 0) begin
				$error("response transfer with nothing expected: status %0d used %0d",
					rsp.status, rsp.used_total);
				fail_count++;
			end else begin
				oldest_expected = expected_responses.pop_front();
				compare_field("status", DATA_W'(oldest_expected.status), DATA_W'(rsp.status));
				compare_field("released", oldest_expected.released, rsp.released);
				compare_field("used_total", oldest_expected.used_total, rsp.used_total);
				compare_field("free_total", oldest_expected.free_total, rsp.free_total);
				status_count[oldest_expected.status]++;
				responses_checked++;
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d responses outstanding",
				cycle_count, expected_responses.size());
			$display("swap_space_quota_table verification failed");
			$finish;
		end
	end

	// stimulus and run control
	initial begin
		logic [DATA_W-1:0] phase_capacity [4];
		arst_n     = 1'b0;
		req.valid  = 1'b0;
		req.kind   = KIND_RESERVE;
		req.pid    = '0;
		req.amount = '0;
		rsp.ready  = 1'b0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;

		quota_capacity = CAPACITY_RESET;
		quota_used     = '0;
		for (int i = 0; i < ENTRIES; i++)
			quota_valid[i] = 1'b0;
		id_pool[0] = '0;
		id_pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++)
			id_pool[i] = DATA_W'($urandom);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part at the reset capacity of 512
		queue_request(KIND_RELEASE, 16'd5, 16'hFFFF);     // release on an empty table
		queue_request(KIND_RESERVE, 16'h0000, 16'd0);     // zero amount is stored
		queue_request(KIND_RESERVE, 16'hFFFF, 16'd100);
		queue_request(KIND_RESERVE, 16'hFFFF, 16'd200);   // replace, old amount returned
		queue_request(KIND_RESERVE, 16'd1, 16'hFFFF);     // far over capacity
		queue_request(KIND_RESERVE, 16'd2, 16'd312);      // lands exactly on capacity
		queue_request(KIND_RESERVE, 16'd3, 16'd1);        // one over
		queue_request(KIND_RELEASE, 16'd2, 16'd0);
		for (int i = 0; i < 14; i++)
			queue_request(KIND_RESERVE, 16'd10 + 16'(i), 16'd1);
		queue_request(KIND_RESERVE, 16'd40, 16'd1);       // table full
		queue_request(KIND_RESERVE, 16'd41, 16'd400);     // space refusal wins over full
		queue_request(KIND_RELEASE, 16'h0000, 16'hFFFF);
		queue_request(KIND_RESERVE, 16'd42, 16'd7);       // takes the lowest free slot
		wait_until_idle();

		// random part: the widest, zero, a lowered and a random capacity
		phase_capacity[0] = 16'hFFFF;
		phase_capacity[1] = 16'd0;
		phase_capacity[2] = 16'd300;
		phase_capacity[3] = DATA_W'($urandom_range(1, 65534));
		for (int p = 0; p < 4; p++) begin
			write_capacity(phase_capacity[p]);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				pending_requests.push_back(random_request());
				// in the first phase the sender holds off midway until all responses are in
				if (p == 0 && n == ITEMS_PER_PHASE / 2)
					wait_until_idle();
			end
			wait_until_idle();
		end

		$display("%0d requests under %0d capacity settings, %0d responses checked",
			requests_accepted, capacity_settings, responses_checked);
		$display("outcomes: %0d done, %0d no space, %0d table full, %0d not found",
			status_count[STAT_DONE], status_count[STAT_NO_SPACE],
			status_count[STAT_FULL], status_count[STAT_NOT_FOUND]);
		if (fail_count == 0) begin
			$display("swap_space_quota_table verification clean");
		end else begin
			$display("swap_space_quota_table verification failed");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/sqt_pkg.sv
rtl/sqt_if.sv
rtl/sqt_ram.sv
rtl/swap_space_quota_table.sv
dv/testbench.sv
